// ===== design/ddodo_pkg.sv =====
// Shared widths, register codes and constants for the differential-drive odometry block.
`default_nettype none

package ddodo_pkg;

  localparam int ANGLE_W    = 32;
  localparam int STAMP_W    = 32;
  localparam int POS_W      = 32;
  localparam int HEAD_W     = 16;
  localparam int SPEED_W    = 32;
  localparam int RADIUS_W   = 16;
  localparam int INV_SEP_W  = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHEEL_RADIUS = 1'b0,
    REG_INV_SEP      = 1'b1
  } cfg_reg_e;

  localparam logic [RADIUS_W-1:0]  RADIUS_RESET  = 16'd2163;
  localparam logic [INV_SEP_W-1:0] INV_SEP_RESET = 24'd385506;

  // CORDIC start vector (limit inverse gain, Q1.30)
  localparam logic [31:0] START_GAIN = 32'd652032874;
  // 2^32 / (2 pi)
  localparam logic [31:0] RAD_TO_BAM = 32'd683565276;
  localparam logic [31:0] US_PER_S   = 32'd1000000;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/ddodo_if.sv =====
// Request channel interfaces: wheel sample input and pose/velocity output.
`default_nettype none

interface ddodo_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [ddodo_pkg::ANGLE_W-1:0]      left_wheel_angle;
  logic signed [ddodo_pkg::ANGLE_W-1:0]      right_wheel_angle;
  logic        [ddodo_pkg::STAMP_W-1:0]      timestamp_us;

  modport source(output valid, left_wheel_angle, right_wheel_angle, timestamp_us,
                 input ready);
  modport sink(input valid, left_wheel_angle, right_wheel_angle, timestamp_us,
               output ready);
endinterface

interface ddodo_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [ddodo_pkg::POS_W-1:0]        x_position;
  logic signed [ddodo_pkg::POS_W-1:0]        y_position;
  logic        [ddodo_pkg::HEAD_W-1:0]       heading;
  logic signed [ddodo_pkg::SPEED_W-1:0]      linear_speed;
  logic signed [ddodo_pkg::SPEED_W-1:0]      turn_rate;

  modport source(output valid, x_position, y_position, heading, linear_speed, turn_rate,
                 input ready);
  modport sink(input valid, x_position, y_position, heading, linear_speed, turn_rate,
               output ready);
endinterface

`default_nettype wire

// ===== design/ddodo_mul.sv =====
// Unsigned radix-4 serial multiplier: two multiplier bits per cycle.
`default_nettype none

module ddodo_mul #(
  parameter int AW = 49,
  parameter int BW = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [AW-1:0]    a_i,
  input  wire logic [BW-1:0]    b_i,
  output logic                  done_o,
  output logic [AW+BW-1:0]      prod_o
);

  localparam int CNT_W = $clog2(BW/2 + 1);

  logic [AW-1:0]    a_q;
  logic [AW+BW-1:0] p_q, p_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [AW+1:0]    addend, top;

  always_comb begin
    addend = (p_q[0] ? (AW+2)'(a_q) : '0) + (p_q[1] ? (AW+2)'({a_q, 1'b0}) : '0);
    top    = (AW+2)'(p_q[AW+BW-1:BW]) + addend;
    p_d    = {top, p_q[BW-1:2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(BW/2);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{AW{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

`default_nettype wire

// ===== design/ddodo_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
`default_nettype none

module ddodo_div #(
  parameter int NW = 52,
  parameter int DW = 31
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quo_o
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    den_q, rem_q, rem_d;
  logic [NW-1:0]    quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q, qbit;
  logic [DW:0]      r2;
  logic [DW+1:0]    diff;

  always_comb begin
    r2    = {rem_q, quo_q[NW-1]};
    diff  = {1'b0, r2} - {2'b00, den_q};
    qbit  = !diff[DW+1];
    rem_d = qbit ? diff[DW-1:0] : r2[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== design/diff_drive_odometry.sv =====
// Differential-drive odometry top level: sequencer, CORDIC and pose state.
`default_nettype none

// Integrates wheel angle samples into a planar pose. Each request carries both
// absolute wheel angles and a microsecond stamp; a request whose stamp does not
// move forward (signed delta zero or negative) is taken and dropped with no
// result and no state change. Otherwise the block forms arc and heading change,
// rotates the heading, advances x/y by arc*cos/sin of the new heading, and
// returns pose plus speed (arc/dt) and turn rate (turn/dt), saturated.
// One item at a time: in_ch.ready is high only while idle. A kept request runs
// eight products through one radix-4 serial multiplier, the p1*inverse_separation
// product chained straight on from p1; CORDIC setup, rotations and quadrant map;
// the two restoring divides, run side by side; and posting the result on the way
// back to idle. A dropped request is taken while idle and leaves the block idle.
// A finished result waits in the output register while the next request is
// taken; if it is still waiting when the next one is done, the block stalls.
// The user must write the registers (cfg_we_i/cfg_index_i/cfg_data_i) only
// while idle; the block itself does not enforce it.
module diff_drive_odometry #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ddodo_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ddodo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ddodo_in_if.sink                              in_ch,
  ddodo_out_if.source                           out_ch
);

  localparam int AW     = 49;        // multiplicand: up to |p1|
  localparam int BW     = 32;        // multiplier operand
  localparam int PW     = AW + BW;
  localparam int SW     = PW + 1;    // signed product
  localparam int NW     = 52;        // speed numerator
  localparam int DW     = 31;        // positive time delta
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic signed [SW-1:0] ONE = 1;

  typedef enum logic [4:0] {
    S_IDLE, S_L_ARC, S_W_ARC, S_L_P1, S_W_P1, S_W_TURN, S_L_BAM, S_W_BAM,
    S_C_INIT, S_CORDIC, S_C_MAP, S_L_X, S_W_X, S_L_Y, S_W_Y,
    S_L_LIN, S_W_LIN, S_L_RATE, S_W_RATE, S_L_DIV, S_W_DIV, S_OUT
  } state_e;

  state_e state_q;

  logic [ddodo_pkg::RADIUS_W-1:0]  rad_q;
  logic [ddodo_pkg::INV_SEP_W-1:0] isep_q;
  logic [31:0] prev_l_q, prev_r_q, stamp_q, pos_x_q, pos_y_q, head_q;
  logic signed [32:0] sum_q, dif_q;
  logic [DW-1:0] dt_q;
  logic signed [31:0] arc_q, turn_q;
  logic [1:0] quad_q;
  logic signed [33:0] cx_q, cy_q, cs_q, sn_q;
  logic signed [32:0] cz_q;
  logic [STEP_W-1:0] step_q;
  logic [NW-1:0] num_lin_q, num_rate_q;
  logic mul_neg_q, mul_neg_d;
  logic out_valid_q;
  logic out_load;
  logic signed [31:0] out_x_q, out_y_q, out_lin_q, out_rate_q;
  logic [15:0] out_head_q;

  // input side
  logic        in_acc, keep;
  logic [31:0] dtu, dl, dr;

  // multiplier
  logic          mul_start, mul_done;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] mul_prod;
  logic signed [SW-1:0] prod_s, rnd_arc, rnd_turn, rnd_bam, rnd_pos;
  logic [33:0] cs_mag, sn_mag;

  // divider
  logic          div_start, div_done_l, div_done_r;
  logic [NW-1:0] quo_l, quo_r;

  // CORDIC step
  logic signed [33:0] xs, ys, cx_d, cy_d, cs_d, sn_d;
  logic signed [32:0] at, cz_d;
  logic [31:0] z_init;
  logic [1:0]  quad_d;

  function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
    if (v > $signed(SW'(32'h7fff_ffff)))       return 32'h7fff_ffff;
    else if (v < -$signed(SW'(33'h0_8000_0000))) return 32'h8000_0000;
    else                                      return v[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic logic [32:0] abs33(input logic [32:0] v);
    return v[32] ? -v : v;
  endfunction

  function automatic logic [33:0] abs34(input logic [33:0] v);
    return v[33] ? -v : v;
  endfunction

  // rounded quotient magnitude with sign, then saturation
  function automatic logic [31:0] speed_sat(input logic [NW-1:0] q, input logic neg);
    if (|q[NW-1:31]) return neg ? 32'h8000_0000 : 32'h7fff_ffff;
    else             return neg ? -q[31:0] : q[31:0];
  endfunction

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign dtu         = in_ch.timestamp_us - stamp_q;
  assign keep        = (dtu != '0) && !dtu[31];
  assign dl          = in_ch.left_wheel_angle - prev_l_q;
  assign dr          = in_ch.right_wheel_angle - prev_r_q;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ch.ready);
  assign cs_mag      = abs34(cs_q);
  assign sn_mag      = abs34(sn_q);

  // product in two's complement and the roundings taken from it
  always_comb begin
    prod_s   = mul_neg_q ? -$signed({1'b0, mul_prod}) : $signed({1'b0, mul_prod});
    rnd_arc  = (prod_s + (ONE <<< FRACTION_BITS)) >>> (FRACTION_BITS + 1);
    rnd_turn = (prod_s + (ONE <<< (2*FRACTION_BITS - 1))) >>> (2*FRACTION_BITS);
    rnd_bam  = (prod_s + (ONE <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    rnd_pos  = (prod_s + (ONE <<< 29)) >>> 30;
  end

  // multiplier launch: operands come from registers
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_neg_d = mul_neg_q;
    case (state_q)
      S_L_ARC: begin
        mul_start = 1'b1;
        mul_a     = AW'(abs33(sum_q));
        mul_b     = BW'(rad_q);
        mul_neg_d = sum_q[32];
      end
      S_L_P1: begin
        mul_start = 1'b1;
        mul_a     = AW'(abs33(dif_q));
        mul_b     = BW'(rad_q);
        mul_neg_d = dif_q[32];
      end
      S_W_P1: begin
        // |p1| is the magnitude just produced; sign carries over
        mul_start = mul_done;
        mul_a     = mul_prod[AW-1:0];
        mul_b     = BW'(isep_q);
      end
      S_L_BAM: begin
        mul_start = 1'b1;
        mul_a     = AW'(abs32(turn_q));
        mul_b     = ddodo_pkg::RAD_TO_BAM;
        mul_neg_d = turn_q[31];
      end
      S_L_X: begin
        mul_start = 1'b1;
        mul_a     = AW'(abs32(arc_q));
        mul_b     = cs_mag[BW-1:0];
        mul_neg_d = arc_q[31] ^ cs_q[33];
      end
      S_L_Y: begin
        mul_start = 1'b1;
        mul_a     = AW'(abs32(arc_q));
        mul_b     = sn_mag[BW-1:0];
        mul_neg_d = arc_q[31] ^ sn_q[33];
      end
      S_L_LIN: begin
        mul_start = 1'b1;
        mul_a     = AW'(abs32(arc_q));
        mul_b     = ddodo_pkg::US_PER_S;
        mul_neg_d = 1'b0;
      end
      S_L_RATE: begin
        mul_start = 1'b1;
        mul_a     = AW'(abs32(turn_q));
        mul_b     = ddodo_pkg::US_PER_S;
        mul_neg_d = 1'b0;
      end
      default: ;
    endcase
  end

  assign div_start = (state_q == S_L_DIV);

  // CORDIC: one rotation per cycle, floor shifts
  always_comb begin
    xs = cx_q >>> step_q;
    ys = cy_q >>> step_q;
    at = $signed({1'b0, ddodo_pkg::atan_bam(5'(step_q))});
    if (!cz_q[32]) begin
      cx_d = cx_q - ys;
      cy_d = cy_q + xs;
      cz_d = cz_q - at;
    end else begin
      cx_d = cx_q + ys;
      cy_d = cy_q - xs;
      cz_d = cz_q + at;
    end
    // quarter-turn reduction into [-90, 0) degrees
    quad_d = 2'((head_q + 32'h4000_0000) >> 30);
    z_init = head_q - {quad_d, 30'b0};
    case (quad_q)
      2'd0:    begin cs_d = cx_q;  sn_d = cy_q;  end
      2'd1:    begin cs_d = -cy_q; sn_d = cx_q;  end
      2'd2:    begin cs_d = -cx_q; sn_d = -cy_q; end
      default: begin cs_d = cy_q;  sn_d = -cx_q; end
    endcase
  end

  // sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rad_q       <= ddodo_pkg::RADIUS_RESET;
      isep_q      <= ddodo_pkg::INV_SEP_RESET;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      stamp_q     <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
      mul_neg_q   <= 1'b0;
      step_q      <= '0;
    end else begin
      mul_neg_q <= mul_neg_d;

      if (cfg_we_i) begin
        unique case (ddodo_pkg::cfg_reg_e'(cfg_index_i))
          ddodo_pkg::REG_WHEEL_RADIUS: rad_q  <= cfg_data_i[ddodo_pkg::RADIUS_W-1:0];
          ddodo_pkg::REG_INV_SEP:      isep_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_acc && keep) begin
            prev_l_q <= in_ch.left_wheel_angle;
            prev_r_q <= in_ch.right_wheel_angle;
            stamp_q  <= in_ch.timestamp_us;
            dt_q     <= dtu[DW-1:0];
            sum_q    <= {dl[31], dl} + {dr[31], dr};
            dif_q    <= {dr[31], dr} - {dl[31], dl};
            state_q  <= S_L_ARC;
          end
        end
        S_L_ARC: state_q <= S_W_ARC;
        S_W_ARC: begin
          if (mul_done) begin
            arc_q   <= sat32(rnd_arc);
            state_q <= S_L_P1;
          end
        end
        S_L_P1: state_q <= S_W_P1;
        S_W_P1: if (mul_done) state_q <= S_W_TURN;
        S_W_TURN: begin
          if (mul_done) begin
            turn_q  <= sat32(rnd_turn);
            state_q <= S_L_BAM;
          end
        end
        S_L_BAM: state_q <= S_W_BAM;
        S_W_BAM: begin
          if (mul_done) begin
            head_q  <= head_q + rnd_bam[31:0];
            state_q <= S_C_INIT;
          end
        end
        S_C_INIT: begin
          quad_q  <= quad_d;
          cz_q    <= {z_init[31], z_init};
          cx_q    <= $signed({2'b00, ddodo_pkg::START_GAIN});
          cy_q    <= '0;
          step_q  <= '0;
          state_q <= S_CORDIC;
        end
        S_CORDIC: begin
          cx_q   <= cx_d;
          cy_q   <= cy_d;
          cz_q   <= cz_d;
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(CORDIC_STEPS - 1)) state_q <= S_C_MAP;
        end
        S_C_MAP: begin
          cs_q    <= cs_d;
          sn_q    <= sn_d;
          state_q <= S_L_X;
        end
        S_L_X: state_q <= S_W_X;
        S_W_X: begin
          if (mul_done) begin
            pos_x_q <= pos_x_q + rnd_pos[31:0];
            state_q <= S_L_Y;
          end
        end
        S_L_Y: state_q <= S_W_Y;
        S_W_Y: begin
          if (mul_done) begin
            pos_y_q <= pos_y_q + rnd_pos[31:0];
            state_q <= S_L_LIN;
          end
        end
        S_L_LIN: state_q <= S_W_LIN;
        S_W_LIN: begin
          if (mul_done) begin
            // add half the divisor: rounds the magnitude to nearest
            num_lin_q <= mul_prod[NW-1:0] + NW'(dt_q >> 1);
            state_q   <= S_L_RATE;
          end
        end
        S_L_RATE: state_q <= S_W_RATE;
        S_W_RATE: begin
          if (mul_done) begin
            num_rate_q <= mul_prod[NW-1:0] + NW'(dt_q >> 1);
            state_q    <= S_L_DIV;
          end
        end
        S_L_DIV: state_q <= S_W_DIV;
        S_W_DIV: if (div_done_l && div_done_r) state_q <= S_OUT;
        S_OUT: begin
          // quotients hold until the next divide starts
          if (out_load) begin
            out_x_q     <= pos_x_q;
            out_y_q     <= pos_y_q;
            out_head_q  <= head_q[31:16];
            out_lin_q   <= speed_sat(quo_l, arc_q[31]);
            out_rate_q  <= speed_sat(quo_r, turn_q[31]);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  ddodo_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  ddodo_div #(.NW(NW), .DW(DW)) u_div_lin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_lin_q),
    .den_i   (dt_q),
    .done_o  (div_done_l),
    .quo_o   (quo_l)
  );

  ddodo_div #(.NW(NW), .DW(DW)) u_div_rate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_rate_q),
    .den_i   (dt_q),
    .done_o  (div_done_r),
    .quo_o   (quo_r)
  );

  assign out_ch.valid        = out_valid_q;
  assign out_ch.x_position   = out_x_q;
  assign out_ch.y_position   = out_y_q;
  assign out_ch.heading      = out_head_q;
  assign out_ch.linear_speed = out_lin_q;
  assign out_ch.turn_rate    = out_rate_q;

endmodule

`default_nettype wire

// ===== design/ddodo_chk.sv =====
// Port-level checker for the odometry block, bound to the top level.
`default_nettype none

module ddodo_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_x_i,
  input wire logic [15:0] out_head_i
);

  // held result must not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) && $stable(out_head_i))
    else $error("result changed while stalled");

  // a result never appears on the edge right after a request is taken
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i))
    else $error("result too soon after request");

  // a fresh result is posted on the way back to idle
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("block not idle after posting a result");

endmodule

bind diff_drive_odometry ddodo_chk u_ddodo_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_x_i     (out_ch.x_position),
  .out_head_i  (out_ch.heading)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the differential-drive odometry block.
`timescale 1ns / 100ps

module testbench;

  localparam int NUM_STEPS   = 16;
  localparam int FRAC        = 16;
  localparam int SETTLE      = 300;   // cycles for a dropped request to finish
  localparam int HALF_PERIOD = 6;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] stamp;
  } sample_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] head;
    logic [31:0] lin;
    logic [31:0] rate;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ddodo_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ddodo_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  ddodo_in_if  in_ch ();
  ddodo_out_if out_ch ();

  diff_drive_odometry DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Predictor state: registers and pose
  logic [15:0] radius_q;
  logic [23:0] inv_sep_q;
  logic [31:0] prev_left_q, prev_right_q, pose_x_q, pose_y_q, heading_q, stamp_q;

  pose_t expected_poses[$];
  int    mismatches = 0;
  int    kept_count = 0;
  int    hold_off_cycles = 0;   // one-shot long receiver stall
  bit    steady_sink = 1'b0;    // receiver never stalls while set
  bit    steady_source = 1'b0;  // sender never gaps while set

  // atan(2^-i) in binary angle units
  const logic [31:0] atan_steps[30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1};

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // rounds to nearest, ties away from zero; d > 0
  function automatic longint rounded_div(longint n, longint d);
    longint mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  // cos/sin of a binary angle in Q1.30
  function automatic void rotate_heading(input logic [31:0] ang,
                                         output longint cs, output longint sn);
    logic [1:0]  quad;
    logic [31:0] red;
    longint z, x, y, nx;
    quad = 2'((ang + 32'h4000_0000) >> 30);
    red = ang - {quad, 30'b0};
    z = longint'($signed(red));
    x = 652032874;
    y = 0;
    for (int i = 0; i < NUM_STEPS && i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(atan_steps[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(atan_steps[i]);
      end
      x = nx;
    end
    case (quad)
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  // Advances the pose for one sample; returns 0 when the sample is dropped.
  function automatic bit integrate_sample(input sample_t s, output pose_t p);
    logic [31:0] dtu;
    longint dl, dr, arc, p1, pa, pb, turn, dbam, cs, sn, lin, rate, dt;
    dtu = s.stamp - stamp_q;
    if (dtu == 0 || dtu[31]) return 1'b0;
    dl = longint'($signed(s.left - prev_left_q));
    dr = longint'($signed(s.right - prev_right_q));
    prev_left_q = s.left;
    prev_right_q = s.right;
    stamp_q = s.stamp;
    arc = clamp32(round_shift((dl + dr) * longint'(radius_q), FRAC + 1));
    p1 = (dr - dl) * longint'(radius_q);
    pa = p1 * longint'(inv_sep_q >> 12);
    pb = p1 * longint'(inv_sep_q & 24'hFFF);
    turn = clamp32((pa + (pb >>> 12) + (longint'(1) <<< (2 * FRAC - 13))) >>> (2 * FRAC - 12));
    dbam = round_shift(turn * 683565276, FRAC);
    heading_q += dbam[31:0];
    rotate_heading(heading_q, cs, sn);
    pose_x_q += 32'(round_shift(arc * cs, 30));
    pose_y_q += 32'(round_shift(arc * sn, 30));
    dt = longint'({32'b0, dtu});
    lin = clamp32(rounded_div(arc * 1000000, dt));
    rate = clamp32(rounded_div(turn * 1000000, dt));
    p.x = pose_x_q;
    p.y = pose_y_q;
    p.head = heading_q[31:16];
    p.lin = lin[31:0];
    p.rate = rate[31:0];
    return 1'b1;
  endfunction

  // Sender: one request, random gap ahead of it; valid stays high across back-to-back items
  task automatic send_sample(input sample_t s);
    int gap;
    pose_t p;
    gap = steady_source ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_wheel_angle <= s.left;
    in_ch.right_wheel_angle <= s.right;
    in_ch.timestamp_us <= s.stamp;
    do @(posedge clk_i); while (!in_ch.ready);
    if (integrate_sample(s, p)) begin
      expected_poses = {expected_poses, p};
      kept_count++;
    end
  endtask

  // Sender pause until every expected pose is back, then let a dropped request finish
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_poses.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // one write cycle, then write enable low again before returning
  task automatic write_reg(input ddodo_pkg::cfg_reg_e idx, input logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == ddodo_pkg::REG_WHEEL_RADIUS) radius_q = val[15:0];
    else inv_sep_q = val;
  endtask

  // Mostly well-formed motion from the current pose; some drops and wild samples
  function automatic sample_t random_sample();
    sample_t s;
    int pick;
    pick = $urandom_range(0, 99);
    s.left = prev_left_q + 32'($signed($urandom_range(0, 2097152)) - 1048576);
    s.right = prev_right_q + 32'($signed($urandom_range(0, 2097152)) - 1048576);
    case ($urandom_range(0, 9))
      0: s.stamp = stamp_q + 1;
      1: s.stamp = stamp_q + $urandom_range(32'h1000_0000, 32'h7FFF_FFFF);
      default: s.stamp = stamp_q + $urandom_range(1, 200000);
    endcase
    if (pick < 8) begin
      // stamp not moving forward: dropped
      s.stamp = stamp_q - $urandom_range(0, 32'h7FFF_FFFF);
    end else if (pick < 18) begin
      s.left = $urandom();
      s.right = $urandom();
      s.stamp = $urandom();
    end else if (pick < 24) begin
      // spin in place, large turn
      s.left = prev_left_q - 32'($urandom_range(0, 32'h00FF_FFFF));
      s.right = prev_right_q + 32'($urandom_range(0, 32'h00FF_FFFF));
    end
    return s;
  endfunction

  task automatic run_random(input int kept_target);
    int goal;
    goal = kept_count + kept_target;
    while (kept_count < goal) send_sample(random_sample());
  endtask

  // Edge values: first sample at stamp zero, extreme deltas, saturating speeds, drops
  task automatic test_directed();
    sample_t s;
    send_sample('{32'd0, 32'd0, 32'd0});                       // dt zero after reset
    send_sample('{32'h7FFF_FFFF, 32'h8000_0000, 32'd1});       // extreme deltas, dt 1
    send_sample('{32'h7FFF_FFFF, 32'h8000_0000, 32'd2});       // no motion
    send_sample('{32'h8000_0000, 32'h7FFF_FFFF, 32'd3});
    send_sample('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0003}); // dt at sign bit: drop
    send_sample('{32'h0000_0000, 32'h0000_0000, 32'h8000_0002}); // dt max positive
    send_sample('{32'h0000_0000, 32'h0000_0000, 32'h8000_0002}); // dt zero: drop
    send_sample('{32'h0000_0000, 32'h0000_0000, 32'h8000_0001}); // dt -1: drop
    send_sample('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}); // stamp near wrap
    send_sample('{32'h0000_0001, 32'h0000_0001, 32'h0000_0010}); // stamp wraps forward
    // walk heading through three of the four quadrants
    for (int i = 0; i < 12; i++) begin
      s.left = prev_left_q - 32'h0030_0000;
      s.right = prev_right_q + 32'h0050_0000;
      s.stamp = stamp_q + 32'd1000;
      send_sample(s);
    end
    drain_results();
  endtask

  task automatic test_registers();
    logic [15:0] radii[3];
    logic [23:0] seps[3];
    radii = '{16'd1, 16'hFFFF, 16'($urandom_range(1, 65535))};
    seps = '{24'd1, 24'hFF_FFFF, 24'($urandom_range(1, 24'hFF_FFFF))};
    foreach (radii[i]) begin
      foreach (seps[j]) begin
        write_reg(ddodo_pkg::REG_WHEEL_RADIUS, {8'd0, radii[i]});
        write_reg(ddodo_pkg::REG_INV_SEP, seps[j]);
        run_random(15);
        drain_results();
      end
    end
    write_reg(ddodo_pkg::REG_WHEEL_RADIUS, {8'd0, ddodo_pkg::RADIUS_RESET});
    write_reg(ddodo_pkg::REG_INV_SEP, ddodo_pkg::INV_SEP_RESET);
  endtask

  // Receiver holds off long enough that the block stalls its input
  task automatic test_backpressure();
    hold_off_cycles = 3000;
    run_random(6);
    drain_results();
  endtask

  task automatic test_random();
    run_random(270);
    steady_sink = 1'b1;
    steady_source = 1'b1;
    run_random(70);
    steady_sink = 1'b0;
    steady_source = 1'b0;
    run_random(330);
  endtask

  // Receiver: random stalls per result, plus the one-shot long hold-off
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      n = steady_sink ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Compare each returned pose against the oldest prediction
  always @(posedge clk_i) begin
    pose_t want, got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.x_position, out_ch.y_position, out_ch.heading,
              out_ch.linear_speed, out_ch.turn_rate};
      if (expected_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose %p", got);
      end else begin
        want = expected_poses.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("pose mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.left_wheel_angle = '0;
    in_ch.right_wheel_angle = '0;
    in_ch.timestamp_us = '0;
    radius_q = ddodo_pkg::RADIUS_RESET;
    inv_sep_q = ddodo_pkg::INV_SEP_RESET;
    prev_left_q = '0;
    prev_right_q = '0;
    pose_x_q = '0;
    pose_y_q = '0;
    heading_q = '0;
    stamp_q = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_registers();
    test_backpressure();
    test_random();
    drain_results();

    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
